// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the pixel message deframer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define PMD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pixel message deframer check failed");

// Sequence must never match outside reset
`define PMD_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("pixel message deframer forbidden condition");

`endif

// ===== sv/pmd_pkg.sv =====
// ---------------------------------------------------------------------------
// Pixel message deframer package
// Request types and fixed constants shared by the deframer modules.
// ---------------------------------------------------------------------------
package pmd_pkg;

  // Header layout: channel, command, length high, length low
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned HdrCntW     = 3;
  localparam int unsigned PixIdxW     = 15;

  typedef enum logic [1:0] {
    HDR_CHANNEL = 2'd0,
    HDR_COMMAND = 2'd1,
    HDR_LEN_HI  = 2'd2,
    HDR_LEN_LO  = 2'd3
  } hdr_pos_e;

  typedef enum logic {
    MODE_STREAM  = 1'b0,
    MODE_RESTART = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PIX_RED   = 2'd0,
    PIX_GREEN = 2'd1,
    PIX_BLUE  = 2'd2,
    PIX_NONE  = 2'd3
  } pix_pos_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic               pixel_valid;
    logic               message_done;
    logic [7:0]         channel;
    logic [PixIdxW-1:0] pixel_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
  } out_req_t;

endpackage

// ===== sv/pmd_parser.sv =====
// ---------------------------------------------------------------------------
// Pixel message deframer parser
// Message parse state and the one-byte step that yields a result request.
// ---------------------------------------------------------------------------
module pmd_parser #(
  parameter int unsigned MAX_PAYLOAD = 65535
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pmd_pkg::in_req_t item_i,
  input  logic [7:0]       pixel_command_i,
  output pmd_pkg::out_req_t result_o
);
  import pmd_pkg::*;

  localparam int unsigned PayloadW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [16:0] MaxLen   = 17'(MAX_PAYLOAD);

  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [7:0]          chan_q, chan_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [7:0]          len_hi_q, len_hi_d;
  logic [7:0]          len_lo_q, len_lo_d;
  logic [PayloadW-1:0] pay_cnt_q, pay_cnt_d;
  pix_pos_e            bip_q, bip_d;
  logic [15:0]         held_q, held_d;
  logic [PixIdxW-1:0]  pix_cnt_q, pix_cnt_d;

  logic [15:0]         hdr_len;
  logic [PayloadW-1:0] sat_len;
  logic [PayloadW-1:0] pay_next;
  logic                in_header;

  // Saturated payload length from the stored header
  assign hdr_len = {len_hi_q, len_lo_q};
  always_comb begin
    if ({1'b0, hdr_len} > MaxLen) begin
      sat_len = PayloadW'(MAX_PAYLOAD);
    end else begin
      sat_len = hdr_len[PayloadW-1:0];
    end
  end

  assign pay_next  = pay_cnt_q + PayloadW'(1);
  assign in_header = (hdr_cnt_q != HdrCntW'(HeaderBytes));

  // One byte step: next parse state and the result fields
  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    chan_d    = chan_q;
    cmd_d     = cmd_q;
    len_hi_d  = len_hi_q;
    len_lo_d  = len_lo_q;
    pay_cnt_d = pay_cnt_q;
    bip_d     = bip_q;
    held_d    = held_q;
    pix_cnt_d = pix_cnt_q;
    result_o  = '0;

    unique case (item_i.mode)
      MODE_RESTART: begin
        hdr_cnt_d = '0;
        chan_d    = '0;
        cmd_d     = '0;
        len_hi_d  = '0;
        len_lo_d  = '0;
        pay_cnt_d = '0;
        bip_d     = PIX_RED;
        held_d    = '0;
        pix_cnt_d = '0;
      end
      MODE_STREAM: begin
        if (in_header) begin
          // Header byte: store it by position
          hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
          unique case (hdr_pos_e'(hdr_cnt_q[1:0]))
            HDR_CHANNEL: chan_d = item_i.data_byte;
            HDR_COMMAND: cmd_d  = item_i.data_byte;
            HDR_LEN_HI:  len_hi_d = item_i.data_byte;
            HDR_LEN_LO: begin
              len_lo_d         = item_i.data_byte;
              result_o.channel = chan_q;
              // Empty payload ends the message on the last header byte
              if ({len_hi_q, item_i.data_byte} == 16'd0) begin
                result_o.message_done = 1'b1;
                hdr_cnt_d = '0;
              end
            end
            default: ;
          endcase
        end else begin
          // Payload byte
          result_o.channel = chan_q;
          pay_cnt_d        = pay_next;
          if (cmd_q == pixel_command_i) begin
            unique case (bip_q)
              PIX_RED: begin
                held_d = {item_i.data_byte, 8'd0};
                bip_d  = PIX_GREEN;
              end
              PIX_GREEN: begin
                held_d = {held_q[15:8], item_i.data_byte};
                bip_d  = PIX_BLUE;
              end
              PIX_BLUE: begin
                result_o.pixel_valid = 1'b1;
                result_o.pixel_index = pix_cnt_q;
                result_o.red         = held_q[15:8];
                result_o.green       = held_q[7:0];
                result_o.blue        = item_i.data_byte;
                pix_cnt_d            = pix_cnt_q + PixIdxW'(1);
                bip_d                = PIX_RED;
                held_d               = '0;
              end
              default: bip_d = PIX_RED;
            endcase
          end
          // Last payload byte closes the message
          if (pay_next >= sat_len) begin
            result_o.message_done = 1'b1;
            hdr_cnt_d = '0;
            pay_cnt_d = '0;
            bip_d     = PIX_RED;
            held_d    = '0;
            pix_cnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      chan_q    <= '0;
      cmd_q     <= '0;
      len_hi_q  <= '0;
      len_lo_q  <= '0;
      pay_cnt_q <= '0;
      bip_q     <= PIX_RED;
      held_q    <= '0;
      pix_cnt_q <= '0;
    end else if (step_i) begin
      hdr_cnt_q <= hdr_cnt_d;
      chan_q    <= chan_d;
      cmd_q     <= cmd_d;
      len_hi_q  <= len_hi_d;
      len_lo_q  <= len_lo_d;
      pay_cnt_q <= pay_cnt_d;
      bip_q     <= bip_d;
      held_q    <= held_d;
      pix_cnt_q <= pix_cnt_d;
    end
  end

endmodule

// ===== sv/pixel_message_deframer.sv =====
// ---------------------------------------------------------------------------
// Pixel message deframer
// Splits a length-prefixed byte stream into messages and emits RGB pixels.
// ---------------------------------------------------------------------------
// Takes one byte request per cycle while the output is not stalled and returns
// exactly one result request for each: an input register feeds the parser,
// whose state update writes the result register, so each result passes the
// input register and then the result register before it is offered; a stalled
// output holds the result and stalls the input only while the input register
// is also full. The sustained rate is one byte per clock while the output is
// not stalled. A set-pixels message (command equal to the pixel_command
// register) yields a pixel on every third payload byte; a restart request
// clears the parse and returns an all-zero result. Write pixel_command only
// while no request is in flight.
module pixel_message_deframer #(
  parameter int unsigned MAX_PAYLOAD = 65535
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pmd_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pmd_pkg::out_req_t out_data_o
);
  import pmd_pkg::*;

  logic [7:0] pixel_command_q;
  logic     in_valid_q;
  in_req_t  in_data_q;
  logic     out_valid_q;
  out_req_t out_data_q;
  out_req_t result;
  logic     out_free;
  logic     step;
  logic     in_take;

  // Pipeline advance
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_command_q <= '0;
    end else if (cfg_we_i) begin
      pixel_command_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_i;
    end
  end

  pmd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (in_data_q),
    .pixel_command_i (pixel_command_q),
    .result_o        (result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/pmd_checker.sv =====
// ---------------------------------------------------------------------------
// Pixel message deframer checker
// Port-level assertions, bound to the deframer top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pmd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pmd_pkg::out_req_t out_data_o
);
  import pmd_pkg::*;

  logic out_held;
  logic in_take;
  logic pix_zero;

  // Handshake terms and the all-zero pixel fields
  assign out_held = out_valid_o && out_stall_i;
  assign in_take  = in_valid_i && !in_stall_o;
  assign pix_zero = (out_data_o.pixel_index == '0) && (out_data_o.red == '0) &&
                    (out_data_o.green == '0) && (out_data_o.blue == '0);

  // A stalled result holds its value
  `PMD_ASSERT(a_out_hold, clk_i, rst_ni, out_held |=> out_valid_o && $stable(out_data_o))

  // Input only stalls when a result is waiting on a stalled output
  `PMD_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_held)

  // Non-pixel results carry zero pixel fields
  `PMD_ASSERT(a_zero_fields, clk_i, rst_ni, out_valid_o && !out_data_o.pixel_valid |-> pix_zero)

  // A fresh result comes from a request accepted through the input register
  `PMD_ASSERT_NEVER(a_no_phantom, clk_i, rst_ni, $rose(out_valid_o) && !$past(in_take, 2))

endmodule

bind pixel_message_deframer pmd_checker u_pmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
